/* rtl/pilp_pkg.sv */
// Shared types and character constants for the prefixed integer literal parser.
package pilp_pkg;

    localparam int CHAR_W  = 8;
    localparam int OUT_W   = 32;
    localparam int COUNT_W = 8;
    localparam int POS_W   = 2;
    localparam int DIGIT_W = 4;

    localparam logic [CHAR_W-1:0]  CH_0       = 8'h30;
    localparam logic [CHAR_W-1:0]  CH_1       = 8'h31;
    localparam logic [CHAR_W-1:0]  CH_9       = 8'h39;
    localparam logic [CHAR_W-1:0]  CH_UP_A    = 8'h41;
    localparam logic [CHAR_W-1:0]  CH_UP_B    = 8'h42;
    localparam logic [CHAR_W-1:0]  CH_UP_F    = 8'h46;
    localparam logic [CHAR_W-1:0]  CH_UP_X    = 8'h58;
    localparam logic [CHAR_W-1:0]  CH_LO_A    = 8'h61;
    localparam logic [CHAR_W-1:0]  CH_LO_Z    = 8'h7a;
    localparam logic [CHAR_W-1:0]  CASE_DELTA = 8'h20;
    localparam logic [CHAR_W-1:0]  HEX_BIAS   = 8'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'hff;

    // position of the next character in the literal
    localparam logic [POS_W-1:0] POS_FIRST  = 2'd0;
    localparam logic [POS_W-1:0] POS_SECOND = 2'd1;
    localparam logic [POS_W-1:0] POS_REST   = 2'd2;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_BIN = 2'd2
    } radix_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             first_zero;
        radix_t           radix;
    } ctrl_t;

    localparam ctrl_t CTRL_RESET = '{position: POS_FIRST, first_zero: 1'b0, radix: RADIX_DEC};

endpackage

/* rtl/pilp_char_if.sv */
// Character input channel: one character of a literal per item.
interface pilp_char_if;
    logic                        valid;
    logic                        ready;
    logic [pilp_pkg::CHAR_W-1:0] char_code;
    logic                        is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

/* rtl/pilp_result_if.sv */
// Result output channel: parsed value and invalid digit count per literal.
interface pilp_result_if;
    logic                         valid;
    logic                         ready;
    logic [pilp_pkg::OUT_W-1:0]   literal_value;
    logic [pilp_pkg::COUNT_W-1:0] bad_digit_count;

    modport source (output valid, output literal_value, output bad_digit_count, input ready);
    modport sink   (input valid, input literal_value, input bad_digit_count, output ready);
endinterface

/* rtl/pilp_fold.sv */
// Per-character step: case folding, prefix detection, digit decode and accumulate.
module pilp_fold #(
    parameter int VALUE_WIDTH = 32
) (
    input  pilp_pkg::ctrl_t                 ctrl,
    input  logic [VALUE_WIDTH-1:0]          acc,
    input  logic [pilp_pkg::COUNT_W-1:0]    bad,
    input  logic [pilp_pkg::CHAR_W-1:0]     char_code,
    output pilp_pkg::ctrl_t                 ctrl_next,
    output logic [VALUE_WIDTH-1:0]          acc_next,
    output logic [pilp_pkg::COUNT_W-1:0]    bad_next
);

    logic [pilp_pkg::CHAR_W-1:0]  c;
    logic                         dec_ok;
    logic                         hex_letter;
    logic                         bin_ok;
    logic [pilp_pkg::DIGIT_W-1:0] dec_digit;
    logic [pilp_pkg::DIGIT_W-1:0] hex_digit;
    logic                         do_fold;
    pilp_pkg::radix_t             fold_radix;
    logic                         digit_ok;
    logic [VALUE_WIDTH-1:0]       folded;

    // upper-case fold, then digit classes
    always_comb
    begin
        c = char_code;
        if (char_code >= pilp_pkg::CH_LO_A && char_code <= pilp_pkg::CH_LO_Z)
        begin
            c = char_code - pilp_pkg::CASE_DELTA;
        end
        dec_ok     = (c >= pilp_pkg::CH_0) && (c <= pilp_pkg::CH_9);
        hex_letter = (c >= pilp_pkg::CH_UP_A) && (c <= pilp_pkg::CH_UP_F);
        bin_ok     = (c == pilp_pkg::CH_0) || (c == pilp_pkg::CH_1);
        dec_digit  = pilp_pkg::DIGIT_W'(c - pilp_pkg::CH_0);
        hex_digit  = dec_ok ? dec_digit
                            : pilp_pkg::DIGIT_W'(c - pilp_pkg::CH_UP_A + pilp_pkg::HEX_BIAS);
    end

    // prefix handling
    always_comb
    begin
        ctrl_next  = ctrl;
        do_fold    = 1'b1;
        fold_radix = ctrl.radix;
        unique case (ctrl.position)
            pilp_pkg::POS_FIRST:
            begin
                fold_radix           = pilp_pkg::RADIX_DEC;
                ctrl_next.radix      = pilp_pkg::RADIX_DEC;
                ctrl_next.first_zero = (c == pilp_pkg::CH_0);
                ctrl_next.position   = pilp_pkg::POS_SECOND;
            end
            pilp_pkg::POS_SECOND:
            begin
                ctrl_next.position = pilp_pkg::POS_REST;
                if (ctrl.first_zero && c == pilp_pkg::CH_UP_X)
                begin
                    ctrl_next.radix = pilp_pkg::RADIX_HEX;
                    do_fold         = 1'b0;
                end
                else if (ctrl.first_zero && c == pilp_pkg::CH_UP_B)
                begin
                    ctrl_next.radix = pilp_pkg::RADIX_BIN;
                    do_fold         = 1'b0;
                end
            end
            default:
            begin
                ctrl_next.position = pilp_pkg::POS_REST;
            end
        endcase
    end

    // digit fold; unused radix code folds as decimal
    always_comb
    begin
        unique case (fold_radix)
            pilp_pkg::RADIX_HEX:
            begin
                digit_ok = dec_ok || hex_letter;
                folded   = (acc << 4) | VALUE_WIDTH'(hex_digit);
            end
            pilp_pkg::RADIX_BIN:
            begin
                digit_ok = bin_ok;
                folded   = (acc << 1) | VALUE_WIDTH'(c[0]);
            end
            default:
            begin
                digit_ok = dec_ok;
                folded   = (acc << 3) + (acc << 1) + VALUE_WIDTH'(dec_digit);
            end
        endcase
    end

    always_comb
    begin
        acc_next = acc;
        bad_next = bad;
        if (do_fold)
        begin
            if (digit_ok)
            begin
                acc_next = folded;
            end
            else if (bad != pilp_pkg::COUNT_MAX)
            begin
                bad_next = bad + 1'b1;
            end
        end
    end

endmodule

/* rtl/prefixed_integer_literal_parser.sv */
// Top level of the prefixed integer literal parser.
//
// Usage:
//   chars  : one ASCII character per item, first character first; is_last
//            marks the final character of a literal. Letters are folded to
//            upper case. "0X"/"0B" as the first two characters select hex or
//            binary; anything else is decimal.
//   result : one item per literal, sent for the item carrying is_last:
//            literal_value (low 32 bits, wrapped) and bad_digit_count
//            (skipped invalid digits, saturating at 255).
// Timing:
//   A character is held in the input register, then one pass through
//   the fold logic (a three-input add of shifted copies for decimal) updates
//   the accumulator; the result register is loaded on that same edge. A final
//   character thus passes the input register and then the result register.
//   Throughput is one character per cycle, but a final character waits while the result register is full.
// Reset clears the parse state and drops both valids. When the receiver
//   stalls, non-final characters keep flowing; a final character waits in
//   the input register until the result register frees up.
module prefixed_integer_literal_parser #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pilp_char_if.sink             chars,
    pilp_result_if.source         result
);

    // input stage
    logic                        in_valid_reg;
    logic [pilp_pkg::CHAR_W-1:0] char_reg;
    logic                        last_reg;

    // parse state
    pilp_pkg::ctrl_t              ctrl_reg;
    pilp_pkg::ctrl_t              ctrl_next;
    logic [VALUE_WIDTH-1:0]       acc_reg;
    logic [VALUE_WIDTH-1:0]       acc_next;
    logic [pilp_pkg::COUNT_W-1:0] bad_reg;
    logic [pilp_pkg::COUNT_W-1:0] bad_next;

    // result stage
    logic                         out_valid_reg;
    logic [pilp_pkg::OUT_W-1:0]   value_reg;
    logic [pilp_pkg::COUNT_W-1:0] count_reg;

    logic out_free;
    logic advance;
    logic take;

    assign out_free = !out_valid_reg || result.ready;
    // a non-final character never needs the result register
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign take     = chars.valid && chars.ready;

    assign chars.ready            = !in_valid_reg || advance;
    assign result.valid           = out_valid_reg;
    assign result.literal_value   = value_reg;
    assign result.bad_digit_count = count_reg;

    pilp_fold #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_fold (
        .ctrl      (ctrl_reg),
        .acc       (acc_reg),
        .bad       (bad_reg),
        .char_code (char_reg),
        .ctrl_next (ctrl_next),
        .acc_next  (acc_next),
        .bad_next  (bad_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            in_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= chars.char_code;
            last_reg <= chars.is_last;
        end
    end

    // parse state: cleared after a literal ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= pilp_pkg::CTRL_RESET;
            acc_reg  <= '0;
            bad_reg  <= '0;
        end
        else if (advance)
        begin
            if (last_reg)
            begin
                ctrl_reg <= pilp_pkg::CTRL_RESET;
                acc_reg  <= '0;
                bad_reg  <= '0;
            end
            else
            begin
                ctrl_reg <= ctrl_next;
                acc_reg  <= acc_next;
                bad_reg  <= bad_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            value_reg <= pilp_pkg::OUT_W'(acc_next);
            count_reg <= bad_next;
        end
    end

    // state is back at its reset value after a literal ends
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=>
            (ctrl_reg == pilp_pkg::CTRL_RESET && acc_reg == '0 && bad_reg == '0))
        else $error("parse state not cleared after final character");

    // a result appears only from a final character
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && last_reg))
        else $error("result valid without a final character");

    // a final character never overwrites an untaken result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |-> out_free)
        else $error("result register overwritten");

    // invalid count only grows within a literal
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !last_reg) |=> (bad_reg >= $past(bad_reg)))
        else $error("invalid digit count decreased");

    // position never goes past the rest-of-literal code
    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.position <= pilp_pkg::POS_REST)
        else $error("bad character position");

endmodule
